/* design/lpfd_pkg.sv */
// Shared types and constants for the length-prefixed frame deframer.
`timescale 1ns / 1ps

package lpfd_pkg;

  // Header layout
  localparam int unsigned HDR_BYTES = 8;
  localparam logic [2:0]  HDR_LAST_IDX = 3'd7;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAGIC   = 2'd0;
  localparam logic [1:0] CFG_MAX_LEN = 2'd1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_HEADER    = 3'd0,
    ST_BODY      = 3'd1,
    ST_BAD_MAGIC = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_TOO_SHORT = 3'd4,
    ST_HALTED    = 3'd5
  } status_t;

  // One result record as it travels from the front end to the output stage
  typedef struct packed {
    status_t     status;
    logic [7:0]  body_byte;
    logic        last;
    logic [7:0]  version;
    logic [15:0] service;
    logic [31:0] total_length;
  } rec_t;

endpackage

/* design/lpfd_front.sv */
// Front end: holds framing state and config, classifies each accepted byte.
`timescale 1ns / 1ps

module lpfd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_wdata,
  output lpfd_pkg::rec_t   rec
);
  import lpfd_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_HALT   = 2'd2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [63:0] hdr_r, hdr_nxt, hdr_ins;
  logic [31:0] rem_r, rem_nxt, rem_dec;
  logic [7:0]  magic_r;
  logic [31:0] max_len_r;
  logic [31:0] len;

  // Header byte insert; first header byte clears the rest
  always_comb begin
    for (int i = 0; i < HDR_BYTES; i++) begin
      if (idx_r == 3'(i)) begin
        hdr_ins[8*i +: 8] = data_byte;
      end else if (idx_r == 3'd0) begin
        hdr_ins[8*i +: 8] = 8'd0;
      end else begin
        hdr_ins[8*i +: 8] = hdr_r[8*i +: 8];
      end
    end
  end

  assign len     = hdr_ins[63:32];
  assign rem_dec = rem_r - 32'd1;

  // Per-byte classification and next state
  always_comb begin
    phase_nxt      = phase_r;
    idx_nxt        = idx_r;
    hdr_nxt        = hdr_r;
    rem_nxt        = rem_r;
    rec.status     = ST_HEADER;
    rec.body_byte  = 8'd0;
    rec.last       = 1'b0;
    case (phase_r)
      PH_HALT: begin
        rec.status = ST_HALTED;
      end
      PH_BODY: begin
        rec.status    = ST_BODY;
        rec.body_byte = data_byte;
        rem_nxt       = rem_dec;
        if (rem_dec == 32'd0) begin
          rec.last  = 1'b1;
          phase_nxt = PH_HEADER;
          idx_nxt   = 3'd0;
        end
      end
      default: begin
        // awaiting header (also the unused phase code)
        hdr_nxt   = hdr_ins;
        phase_nxt = PH_HEADER;
        if (idx_r != HDR_LAST_IDX) begin
          idx_nxt = idx_r + 3'd1;
        end else begin
          idx_nxt = 3'd0;
          if (hdr_ins[15:8] != magic_r) begin
            rec.status = ST_BAD_MAGIC;
            phase_nxt  = PH_HALT;
          end else if (len > max_len_r) begin
            rec.status = ST_TOO_LONG;
            phase_nxt  = PH_HALT;
          end else if (len < 32'(HDR_BYTES)) begin
            rec.status = ST_TOO_SHORT;
            phase_nxt  = PH_HALT;
          end else if (len == 32'(HDR_BYTES)) begin
            rec.last = 1'b1;
          end else begin
            rem_nxt   = len - 32'(HDR_BYTES);
            phase_nxt = PH_BODY;
          end
        end
      end
    endcase
    rec.version      = hdr_nxt[7:0];
    rec.service      = hdr_nxt[31:16];
    rec.total_length = hdr_nxt[63:32];
  end

  // State and config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      idx_r     <= 3'd0;
      hdr_r     <= 64'd0;
      rem_r     <= 32'd0;
      magic_r   <= 8'd0;
      max_len_r <= 32'hFFFF_FFFF;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        idx_r   <= idx_nxt;
        hdr_r   <= hdr_nxt;
        rem_r   <= rem_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAGIC:   magic_r   <= cfg_wdata[7:0];
          CFG_MAX_LEN: max_len_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Halt is sticky until reset
  assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HALT |=> phase_r == PH_HALT)
    else $error("left halted phase without reset");

  // A completed message is only marked on a header or body byte
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && rec.last |-> rec.status == ST_HEADER || rec.status == ST_BODY)
    else $error("last marked on an error or halted byte");

  // A header error always moves to halted
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && (rec.status == ST_BAD_MAGIC || rec.status == ST_TOO_LONG ||
               rec.status == ST_TOO_SHORT) |=> phase_r == PH_HALT)
    else $error("header error did not halt");

endmodule

/* design/lpfd_fifo.sv */
// Short request queue between the front end and the output stage.
`timescale 1ns / 1ps

module lpfd_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lpfd_pkg::rec_t wr_rec,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output lpfd_pkg::rec_t rd_rec
);
  import lpfd_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rec_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_rec    = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_rec;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !not_empty) && !(push && full))
    else $error("queue underflow or overflow");

endmodule

/* design/lpfd_out.sv */
// Output stage: pulls records from the queue into the result register.
`timescale 1ns / 1ps

module lpfd_out (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  lpfd_pkg::rec_t q_rec,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output lpfd_pkg::rec_t out_rec
);
  import lpfd_pkg::*;

  logic out_valid_r;
  rec_t out_rec_r;

  // Load when the register is empty or its request leaves this cycle
  assign q_pop     = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_rec   = out_rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_rec_r <= q_rec;
    end
  end

endmodule

/* design/length_prefixed_frame_deframer.sv */
// Top level of the length-prefixed frame deframer.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready/in_data_byte) takes one stream byte per
//   request. Every accepted byte yields exactly one result request on the
//   out_ channel: status, passed-through body byte, last-of-message flag and
//   the header fields (version, service, total_length) as held so far.
//   Config port: cfg_we with cfg_index 0 writes the expected magic byte,
//   index 1 the largest allowed total length; other indexes are ignored.
//   Write config only while no request is in flight.
//   Throughput: one byte per cycle while in_ready is high, set by the
//   combinational classify step in the front end. A result passes through
//   the queue, written when its byte is accepted, and then the output
//   register, which loads once it is empty or its request leaves.
//   Receiver stall: the output register holds its request, the queue of
//   FIFO_DEPTH entries fills, then in_ready drops; up to FIFO_DEPTH + 1
//   results are buffered, none is lost.
//   Reset: no outputs valid, queue empty, deframer waits for a header, magic
//   is 0 and max length is all ones. A header error halts the deframer
//   (status halted for every later byte) until reset.
module length_prefixed_frame_deframer #(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [7:0]  out_body_byte,
  output logic        out_last,
  output logic [7:0]  out_version,
  output logic [15:0] out_service,
  output logic [31:0] out_total_length,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import lpfd_pkg::*;

  logic accept, q_full, q_valid, q_pop;
  rec_t front_rec, q_rec, out_rec;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  lpfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_data_byte),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .rec       (front_rec)
  );

  lpfd_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .wr_rec    (front_rec),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rd_rec    (q_rec)
  );

  lpfd_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_rec     (q_rec),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rec   (out_rec)
  );

  assign out_status       = out_rec.status;
  assign out_body_byte    = out_rec.body_byte;
  assign out_last         = out_rec.last;
  assign out_version      = out_rec.version;
  assign out_service      = out_rec.service;
  assign out_total_length = out_rec.total_length;

endmodule
